@@ rtl/core/contactor_close_open_sequencer_macros.svh @@
// Assertion macros shared by the contactor sequencer RTL.
`ifndef CONTACTOR_CLOSE_OPEN_SEQUENCER_MACROS_SVH
`define CONTACTOR_CLOSE_OPEN_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCOS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ccos assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CCOS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ccos assertion failed");

`endif

@@ rtl/core/ccos_pkg.sv @@
// Types and constants for the contactor close/open sequencer.
`default_nettype none

package ccos_pkg;

    localparam int ADC_BITS       = 12;
    localparam int TIMER_BITS     = 16;
    localparam int ATTEMPT_BITS   = 8;
    localparam int CFG_DATA_BITS  = (TIMER_BITS > ADC_BITS) ? TIMER_BITS : ADC_BITS;
    localparam int CFG_INDEX_BITS = 3;

    // operation codes; code 3 behaves as a tick
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_OPEN  = 2'd2;

    // reported switch state
    localparam logic [1:0] ST_OPEN    = 2'd0;
    localparam logic [1:0] ST_CLOSING = 2'd1;
    localparam logic [1:0] ST_CLOSED  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IS_CONTACTOR = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SETTLE       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RETRY_WAIT   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ATTEMPTS = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD    = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CLOSE_SETTLE,
        PH_CLOSE_RETRY,
        PH_OPEN_SETTLE
    } phase_t;

    typedef struct packed {
        logic [1:0]          operation;
        logic                sense_level;
        logic [ADC_BITS-1:0] adc_level;
    } req_word_t;

    typedef struct packed {
        logic       drive;
        logic [1:0] contact_state;
        logic       busy_res;
        logic       done_res;
        logic       success;
        logic       switch_error;
        logic       bps_error;
    } rsp_word_t;

    typedef struct packed {
        logic                    is_contactor;
        logic [TIMER_BITS-1:0]   settle_ticks;
        logic [TIMER_BITS-1:0]   retry_wait_ticks;
        logic [ATTEMPT_BITS-1:0] max_attempts;
        logic [ADC_BITS-1:0]     precharge_threshold;
    } cfg_t;

    typedef struct packed {
        phase_t                  phase;
        logic [TIMER_BITS-1:0]   wait_count;
        logic [ATTEMPT_BITS-1:0] attempt_count;
        logic                    drive_level;
        logic [1:0]              state_code;
        logic                    close_error;
        logic                    open_error;
    } ctl_state_t;

    localparam cfg_t CFG_RESET = '{
        is_contactor:        1'b1,
        settle_ticks:        TIMER_BITS'(100),
        retry_wait_ticks:    TIMER_BITS'(100),
        max_attempts:        ATTEMPT_BITS'(3),
        precharge_threshold: ADC_BITS'(2048)
    };

    localparam ctl_state_t STATE_RESET = '{
        phase:         PH_IDLE,
        wait_count:    '0,
        attempt_count: '0,
        drive_level:   1'b0,
        state_code:    ST_OPEN,
        close_error:   1'b0,
        open_error:    1'b0
    };

endpackage

`default_nettype wire

@@ rtl/core/contactor_close_open_sequencer.sv @@
// Top level of the contactor / precharge switch close-open sequencer.
`default_nettype none

// Contactor / precharge close-open sequencer. Each request word is a timer
// tick or a close/open request carrying the sense pin and an ADC sample; each
// word yields exactly one response word with the coil drive, switch state,
// busy/done/success, the sticky switch error flag and the BPS error flag.
// Words move through an input register and a result register with one pass
// of state update logic between them, so one word is taken every clock while
// the output is not stalled; a response is presented from the result register
// and is accepted when the output is not stalled. The rate is set by that
// single-pass state update, which must finish before the next word sees the
// state. A stalled result does not block the input register from filling.
// Configuration writes are always ready and should be issued only while no
// request is in flight; registers: 0 contactor select, 1 settle ticks, 2 retry
// wait ticks, 3 attempt limit, 4 precharge ADC threshold. Writes to other
// indexes are dropped.

`include "contactor_close_open_sequencer_macros.svh"

module contactor_close_open_sequencer (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // request channel
    input  wire                                   req_valid,
    output logic                                  req_stall,
    input  wire ccos_pkg::req_word_t              req_word,
    // response channel
    output logic                                  rsp_valid,
    input  wire                                   rsp_stall,
    output ccos_pkg::rsp_word_t                   rsp_word,
    // configuration write channel
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire [ccos_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire [ccos_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    ccos_pkg::cfg_t       cfg_reg;
    ccos_pkg::ctl_state_t state_reg;
    ccos_pkg::ctl_state_t state_next;
    ccos_pkg::req_word_t  in_word_reg;
    logic                 in_valid_reg;
    ccos_pkg::rsp_word_t  out_word_reg;
    ccos_pkg::rsp_word_t  out_word_next;
    logic                 out_valid_reg;
    logic                 advance;
    logic                 req_take;

    // the input word moves on when the result register is empty or draining
    assign advance   = in_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= ccos_pkg::CFG_RESET;
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ccos_pkg::CFG_IS_CONTACTOR: cfg_reg.is_contactor <= cfg_data[0];
                ccos_pkg::CFG_SETTLE:
                    cfg_reg.settle_ticks <= cfg_data[ccos_pkg::TIMER_BITS-1:0];
                ccos_pkg::CFG_RETRY_WAIT:
                    cfg_reg.retry_wait_ticks <= cfg_data[ccos_pkg::TIMER_BITS-1:0];
                ccos_pkg::CFG_MAX_ATTEMPTS:
                    cfg_reg.max_attempts <= cfg_data[ccos_pkg::ATTEMPT_BITS-1:0];
                ccos_pkg::CFG_THRESHOLD:
                    cfg_reg.precharge_threshold <= cfg_data[ccos_pkg::ADC_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            in_word_reg <= req_word;
    end

    ccos_step u_step (
        .cfg (cfg_reg),
        .cur (state_reg),
        .req (in_word_reg),
        .nxt (state_next),
        .rsp (out_word_next)
    );

    // sequencer state commits when its word enters the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ccos_pkg::STATE_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!rsp_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_word_reg <= out_word_next;
    end

    // checks
    `CCOS_ASSERT_NXT(a_switch_err_sticky, clk, rst_n, state_reg.close_error, state_reg.close_error)
    `CCOS_ASSERT_IMP(a_success_needs_done, clk, rst_n,
        rsp_valid && rsp_word.success, rsp_word.done_res && !rsp_word.busy_res)
    `CCOS_ASSERT_IMP(a_closed_ok_drives, clk, rst_n,
        rsp_valid && rsp_word.success && rsp_word.contact_state == ccos_pkg::ST_CLOSED,
        rsp_word.drive)
    `CCOS_ASSERT_IMP(a_fail_drops_drive, clk, rst_n,
        rsp_valid && rsp_word.done_res && !rsp_word.success,
        !rsp_word.drive && rsp_word.switch_error)
    `CCOS_ASSERT_IMP(a_stall_when_full, clk, rst_n, req_stall,
        in_valid_reg && out_valid_reg && rsp_stall)

endmodule

`default_nettype wire

@@ rtl/core/ccos_step.sv @@
// Single-pass state update of the sequencer for one input word.
`default_nettype none

module ccos_step (
    input  wire ccos_pkg::cfg_t       cfg,
    input  wire ccos_pkg::ctl_state_t cur,
    input  wire ccos_pkg::req_word_t  req,
    output ccos_pkg::ctl_state_t      nxt,
    output ccos_pkg::rsp_word_t       rsp
);

    logic                              fin_done;
    logic                              fin_ok;
    logic                              chk_ok;
    logic                              settle_wait;
    logic [ccos_pkg::TIMER_BITS-1:0]   wait_dec;

    assign chk_ok = cfg.is_contactor ? req.sense_level
                                     : (req.adc_level >= cfg.precharge_threshold);
    // contactor close with a nonzero settle time waits before its sense check
    assign settle_wait = cfg.is_contactor && (cfg.settle_ticks != '0);
    assign wait_dec = (cur.wait_count != '0) ? cur.wait_count - 1'b1 : cur.wait_count;

    // next state
    always_comb
    begin
        logic                              run_entry;
        logic                              run_check;
        logic                              run_open_chk;
        logic [ccos_pkg::ATTEMPT_BITS-1:0] entry_att;
        logic [ccos_pkg::ATTEMPT_BITS-1:0] chk_att;
        logic [ccos_pkg::ATTEMPT_BITS-1:0] chk_att_inc;

        nxt          = cur;
        fin_done     = 1'b0;
        fin_ok       = 1'b0;
        run_entry    = 1'b0;
        run_check    = 1'b0;
        run_open_chk = 1'b0;
        entry_att    = cur.attempt_count;
        chk_att      = cur.attempt_count;

        case (req.operation)
            ccos_pkg::OP_CLOSE:
            begin
                nxt.attempt_count = '0;
                entry_att         = '0;
                run_entry         = 1'b1;
            end
            ccos_pkg::OP_OPEN:
            begin
                nxt.attempt_count = '0;
                nxt.drive_level   = 1'b0;
                nxt.wait_count    = cfg.settle_ticks;
                nxt.phase         = ccos_pkg::PH_OPEN_SETTLE;
                run_open_chk      = (cfg.settle_ticks == '0);
            end
            default:
            begin
                if (cur.phase != ccos_pkg::PH_IDLE)
                begin
                    nxt.wait_count = wait_dec;
                    if (wait_dec == '0)
                    begin
                        unique case (cur.phase)
                            ccos_pkg::PH_CLOSE_SETTLE: run_check    = 1'b1;
                            ccos_pkg::PH_CLOSE_RETRY:  run_entry    = 1'b1;
                            ccos_pkg::PH_OPEN_SETTLE:  run_open_chk = 1'b1;
                            default:                   ;
                        endcase
                    end
                end
            end
        endcase

        // start of a close attempt
        if (run_entry)
        begin
            if (entry_att >= cfg.max_attempts)
            begin
                nxt.close_error = 1'b1;
                nxt.drive_level = 1'b0;
                nxt.state_code  = ccos_pkg::ST_OPEN;
                nxt.phase       = ccos_pkg::PH_IDLE;
                nxt.wait_count  = '0;
                fin_done        = 1'b1;
            end
            else
            begin
                nxt.drive_level = 1'b1;
                if (settle_wait)
                begin
                    nxt.wait_count = cfg.settle_ticks;
                    nxt.phase      = ccos_pkg::PH_CLOSE_SETTLE;
                end
                else
                begin
                    run_check = 1'b1;
                    chk_att   = entry_att;
                end
            end
        end

        // closure check; with no retry wait and no settle wait the repeated
        // checks within one word all see the same sample, so they collapse
        chk_att_inc = (chk_att == '1) ? chk_att : chk_att + 1'b1;
        if (run_check)
        begin
            if (chk_ok)
            begin
                nxt.state_code = ccos_pkg::ST_CLOSED;
                nxt.phase      = ccos_pkg::PH_IDLE;
                nxt.wait_count = '0;
                fin_done       = 1'b1;
                fin_ok         = 1'b1;
            end
            else
            begin
                nxt.state_code    = ccos_pkg::ST_CLOSING;
                nxt.attempt_count = chk_att_inc;
                nxt.wait_count    = cfg.retry_wait_ticks;
                nxt.phase         = ccos_pkg::PH_CLOSE_RETRY;
                if (cfg.retry_wait_ticks == '0)
                begin
                    if (chk_att_inc < cfg.max_attempts && settle_wait)
                    begin
                        nxt.drive_level = 1'b1;
                        nxt.wait_count  = cfg.settle_ticks;
                        nxt.phase       = ccos_pkg::PH_CLOSE_SETTLE;
                    end
                    else
                    begin
                        if (chk_att_inc < cfg.max_attempts)
                            nxt.attempt_count = cfg.max_attempts;
                        nxt.close_error = 1'b1;
                        nxt.drive_level = 1'b0;
                        nxt.state_code  = ccos_pkg::ST_OPEN;
                        nxt.phase       = ccos_pkg::PH_IDLE;
                        nxt.wait_count  = '0;
                        fin_done        = 1'b1;
                    end
                end
            end
        end

        // open check
        if (run_open_chk)
        begin
            if (!cfg.is_contactor || !req.sense_level)
            begin
                nxt.state_code = ccos_pkg::ST_OPEN;
                if (cfg.is_contactor)
                    nxt.open_error = 1'b0;
                nxt.phase      = ccos_pkg::PH_IDLE;
                nxt.wait_count = '0;
                fin_done       = 1'b1;
                fin_ok         = 1'b1;
            end
            else
            begin
                nxt.open_error  = 1'b1;
                nxt.state_code  = ccos_pkg::ST_CLOSED;
                nxt.drive_level = 1'b0;
                nxt.wait_count  = cfg.settle_ticks;
                nxt.phase       = ccos_pkg::PH_OPEN_SETTLE;
            end
        end
    end

    // result word
    always_comb
    begin
        rsp.drive         = nxt.drive_level;
        rsp.contact_state = nxt.state_code;
        rsp.busy_res      = (nxt.phase != ccos_pkg::PH_IDLE);
        rsp.done_res      = fin_done;
        rsp.success       = fin_ok;
        rsp.switch_error  = nxt.close_error;
        rsp.bps_error     = nxt.open_error;
    end

endmodule

`default_nettype wire
